// ===== hw/rtl/tcpop_pkg.sv =====
// tcp option parser package: option kind codes, reset value of the segment size
// and the result record shared by the parser and the top level.
// no dependencies.
`default_nettype none

package tcpop_pkg;

  localparam logic [7:0] OPT_END     = 8'd0;
  localparam logic [7:0] OPT_NOP     = 8'd1;
  localparam logic [7:0] OPT_MSS     = 8'd2;
  localparam logic [7:0] OPT_WSCALE  = 8'd3;
  localparam logic [7:0] OPT_SACK_OK = 8'd4;

  localparam logic [15:0] MSS_DEFAULT = 16'd1460;

  // packed so that the segment size sits in the lowest bits
  typedef struct packed {
    logic        malformed;
    logic        sack_allowed;
    logic [7:0]  window_shift;
    logic [15:0] max_segment_size;
  } result_t;

  localparam int unsigned RESULT_W = $bits(result_t);
  localparam int unsigned TDATA_W  = ((RESULT_W + 7) / 8) * 8;

endpackage

`default_nettype wire

// ===== hw/rtl/tcpop_parse.sv =====
// per-byte parser state machine of the tcp option parser; holds the parse phase
// and the learned option values. depends on tcpop_pkg.
`default_nettype none

module tcpop_parse (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire logic [7:0]        byte_i,
  input  wire logic              last_i,
  output tcpop_pkg::result_t     result_o
);

  typedef enum logic [2:0] {
    PH_KIND    = 3'd0,
    PH_KLEN    = 3'd1,
    PH_MSS_HI  = 3'd2,
    PH_MSS_LO  = 3'd3,
    PH_WS_VAL  = 3'd4,
    PH_UNK_LEN = 3'd5,
    PH_SKIP    = 3'd6,
    PH_DONE    = 3'd7
  } phase_e;

  phase_e      phase_q, phase_d, phase_n;
  logic [7:0]  skip_q, skip_d, skip_n, skip_dec;
  logic [7:0]  high_q, high_d;
  logic [15:0] mss_q, mss_d;
  logic [7:0]  shift_q, shift_d;
  logic        sack_q, sack_d;
  logic        err_q, err_d, err_n;

  always_comb begin
    phase_n  = phase_q;
    skip_n   = skip_q;
    high_d   = high_q;
    mss_d    = mss_q;
    shift_d  = shift_q;
    sack_d   = sack_q;
    err_n    = err_q;
    skip_dec = (skip_q != 8'd0) ? (skip_q - 8'd1) : skip_q;

    unique case (phase_q)
      PH_KIND: begin
        if (byte_i == tcpop_pkg::OPT_END) begin
          phase_n = PH_DONE;
        end else if (byte_i == tcpop_pkg::OPT_NOP) begin
          phase_n = PH_KIND;
        end else if (byte_i >= tcpop_pkg::OPT_MSS && byte_i <= tcpop_pkg::OPT_SACK_OK) begin
          // kind is held in the high byte register while its length passes
          if (byte_i == tcpop_pkg::OPT_SACK_OK) begin
            sack_d = 1'b1;
          end
          high_d  = byte_i;
          phase_n = PH_KLEN;
        end else begin
          phase_n = PH_UNK_LEN;
        end
      end
      PH_KLEN: begin
        if (high_q == tcpop_pkg::OPT_MSS) begin
          phase_n = PH_MSS_HI;
        end else if (high_q == tcpop_pkg::OPT_WSCALE) begin
          phase_n = PH_WS_VAL;
        end else begin
          phase_n = PH_KIND;
        end
      end
      PH_MSS_HI: begin
        high_d  = byte_i;
        phase_n = PH_MSS_LO;
      end
      PH_MSS_LO: begin
        mss_d   = {high_q, byte_i};
        phase_n = PH_KIND;
      end
      PH_WS_VAL: begin
        shift_d = byte_i;
        phase_n = PH_KIND;
      end
      PH_UNK_LEN: begin
        if (byte_i < 8'd2) begin
          err_n   = 1'b1;
          phase_n = PH_DONE;
        end else if (byte_i == 8'd2) begin
          phase_n = PH_KIND;
        end else begin
          skip_n  = byte_i - 8'd2;
          phase_n = PH_SKIP;
        end
      end
      PH_SKIP: begin
        skip_n = skip_dec;
        if (skip_dec == 8'd0) begin
          phase_n = PH_KIND;
        end
      end
      PH_DONE: begin
        phase_n = PH_DONE;
      end
      default: begin
        phase_n = phase_q;
      end
    endcase

    result_o.max_segment_size = mss_d;
    result_o.window_shift     = shift_d;
    result_o.sack_allowed     = sack_d;
    result_o.malformed        = err_n | ((phase_n != PH_KIND) && (phase_n != PH_DONE));

    // end of area: parse position and error start afresh, learned values stay
    if (last_i) begin
      phase_d = PH_KIND;
      skip_d  = 8'd0;
      err_d   = 1'b0;
    end else begin
      phase_d = phase_n;
      skip_d  = skip_n;
      err_d   = err_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_KIND;
      skip_q  <= 8'd0;
      high_q  <= 8'd0;
      mss_q   <= tcpop_pkg::MSS_DEFAULT;
      shift_q <= 8'd0;
      sack_q  <= 1'b0;
      err_q   <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      skip_q  <= skip_d;
      high_q  <= high_d;
      mss_q   <= mss_d;
      shift_q <= shift_d;
      sack_q  <= sack_d;
      err_q   <= err_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tcp_option_parser.sv =====
// top level of the tcp option parser: input register, parser and result register.
// depends on tcpop_pkg and tcpop_parse.
//
// usage: the option area of a tcp header enters on the s_axis channel, one byte
// per item, with s_axis_tlast on its final byte. kinds end, no-op, maximum
// segment size, window scale and sack permitted are decoded, any other kind is
// skipped by its length byte. learned values are kept from one area to the next.
// for every area one result item leaves on m_axis with the current segment size,
// window shift, sack permitted bit and a malformed bit (bad length or an option
// cut off by the end of the area); bytes without tlast give no result.
// throughput: one byte per cycle unless a final byte waits for the result register;
// the parser step between the input register and the result register is combinational.
// result path: the last byte of an area passes the input register, then the parser
// step writes its result into the result register, which drives m_axis.
// reset: segment size returns to 1460, window shift and sack permitted clear,
// and both registers empty.
// stall: a waiting result holds; non-final bytes keep flowing into the parser,
// a final byte waits in the input register until the result register frees,
// and s_axis_tready drops only once the input register is also held.
`default_nettype none

module tcp_option_parser (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output      logic                              s_axis_tready,
  input  wire logic [7:0]                        s_axis_tdata,  // [7:0] option_byte
  input  wire logic                              s_axis_tlast,  // area_last
  output      logic                              m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [15:0] max_segment_size, [23:16] window_shift, [24] sack_allowed,
  // [25] malformed, upper bits zero
  output      logic [tcpop_pkg::TDATA_W-1:0]     m_axis_tdata
);

  logic               in_valid_q;
  logic [7:0]         in_byte_q;
  logic               in_last_q;
  logic               out_valid_q;
  tcpop_pkg::result_t result_q;
  tcpop_pkg::result_t step_result;
  logic               advance;
  logic               in_take;

  // a final byte may only step once the result register can take its result
  assign advance       = in_valid_q && (!in_last_q || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  tcpop_parse u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .byte_i   (in_byte_q),
    .last_i   (in_last_q),
    .result_o (step_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance && in_last_q) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    if (advance && in_last_q) begin
      result_q <= step_result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(tcpop_pkg::TDATA_W - tcpop_pkg::RESULT_W){1'b0}}, result_q};

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !(advance && in_last_q))
    else $error("pending result overwritten");

  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_last_q) |=> m_axis_tvalid)
    else $error("final byte stepped without a result");

  a_take_fills_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> in_valid_q)
    else $error("accepted item lost from input register");

endmodule

`default_nettype wire

// ===== verif/tcp_option_parser_test.sv =====
// self-checking bench for tcp_option_parser: random and directed option areas go in
// on s_axis, results on m_axis are checked against a byte-level parser model.
// depends on tcpop_pkg and the tcp_option_parser rtl.
`default_nettype none

module tcp_option_parser_test;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned RANDOM_ITEMS  = 650;
  localparam int unsigned CALM_FROM     = 300;
  localparam int unsigned CALM_TO       = 700;
  localparam int unsigned DRAIN_CYCLES  = 10;
  localparam int unsigned SHOWN_ERRORS  = 10;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } option_item_t;

  typedef enum logic [2:0] {
    SEEK_KIND,
    KIND_LENGTH,
    MSS_HIGH,
    MSS_LOW,
    SHIFT_VALUE,
    OTHER_LENGTH,
    SKIP_BODY,
    IGNORE_REST
  } parse_phase_e;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [7:0]                      s_axis_tdata  = '0;  // [7:0] option_byte
  logic                            s_axis_tlast  = 1'b0;  // area_last
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  // [15:0] max_segment_size, [23:16] window_shift, [24] sack_allowed, [25] malformed
  logic [tcpop_pkg::TDATA_W-1:0]   m_axis_tdata;

  tcp_option_parser i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tlast,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  option_item_t       pending_bytes_q[$];
  option_item_t       next_byte;
  logic [7:0]         area_buf[$];
  tcpop_pkg::result_t expected_results_q[$];
  tcpop_pkg::result_t seen_result;

  int unsigned cycle_count  = 0;
  int unsigned bytes_total  = 0;
  int unsigned bytes_taken  = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches   = 0;

  // parser model state
  parse_phase_e phase_m;
  logic [7:0]   skip_left_m;
  logic [7:0]   held_byte_m;
  logic [15:0]  mss_m;
  logic [7:0]   shift_m;
  logic         sack_m;
  logic         bad_length_m;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic bit take_pause();
    if (cycle_count >= CALM_FROM && cycle_count < CALM_TO) begin
      return 1'b0;
    end
    return $urandom_range(99) < 29;
  endfunction

  // sender: a new item goes out once the previous one is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_bytes_q.size() != 0 && !take_pause()) begin
        next_byte     = pending_bytes_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= next_byte.value;
        s_axis_tlast  <= next_byte.last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !take_pause();
    end
  end

  task automatic reset_parser_model();
    phase_m      = SEEK_KIND;
    skip_left_m  = '0;
    held_byte_m  = '0;
    mss_m        = tcpop_pkg::MSS_DEFAULT;
    shift_m      = '0;
    sack_m       = 1'b0;
    bad_length_m = 1'b0;
  endtask

  // advances the model by one option byte, queues a result on the last byte
  task automatic parse_option_byte(input logic [7:0] b, input logic last);
    tcpop_pkg::result_t res;
    case (phase_m)
      SEEK_KIND: begin
        if (b == tcpop_pkg::OPT_END) begin
          phase_m = IGNORE_REST;
        end else if (b == tcpop_pkg::OPT_NOP) begin
          phase_m = SEEK_KIND;
        end else if (b == tcpop_pkg::OPT_MSS || b == tcpop_pkg::OPT_WSCALE ||
                     b == tcpop_pkg::OPT_SACK_OK) begin
          // sack permitted counts as soon as its kind is seen
          if (b == tcpop_pkg::OPT_SACK_OK) begin
            sack_m = 1'b1;
          end
          held_byte_m = b;
          phase_m     = KIND_LENGTH;
        end else begin
          phase_m = OTHER_LENGTH;
        end
      end
      KIND_LENGTH: begin
        if (held_byte_m == tcpop_pkg::OPT_MSS) begin
          phase_m = MSS_HIGH;
        end else if (held_byte_m == tcpop_pkg::OPT_WSCALE) begin
          phase_m = SHIFT_VALUE;
        end else begin
          phase_m = SEEK_KIND;
        end
      end
      MSS_HIGH: begin
        held_byte_m = b;
        phase_m     = MSS_LOW;
      end
      MSS_LOW: begin
        mss_m   = {held_byte_m, b};
        phase_m = SEEK_KIND;
      end
      SHIFT_VALUE: begin
        shift_m = b;
        phase_m = SEEK_KIND;
      end
      OTHER_LENGTH: begin
        if (b < 8'd2) begin
          bad_length_m = 1'b1;
          phase_m      = IGNORE_REST;
        end else if (b == 8'd2) begin
          phase_m = SEEK_KIND;
        end else begin
          skip_left_m = b - 8'd2;
          phase_m     = SKIP_BODY;
        end
      end
      SKIP_BODY: begin
        if (skip_left_m != 0) begin
          skip_left_m = skip_left_m - 8'd1;
        end
        if (skip_left_m == 0) begin
          phase_m = SEEK_KIND;
        end
      end
      default: begin
      end
    endcase

    if (last) begin
      res.max_segment_size = mss_m;
      res.window_shift     = shift_m;
      res.sack_allowed     = sack_m;
      res.malformed        = bad_length_m ||
                             (phase_m != SEEK_KIND && phase_m != IGNORE_REST);
      expected_results_q.push_back(res);
      phase_m      = SEEK_KIND;
      skip_left_m  = '0;
      bad_length_m = 1'b0;
    end
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= SHOWN_ERRORS) begin
      $display("mismatch at result %0d, %s: expected %0h, got %0h",
               results_seen, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        parse_option_byte(s_axis_tdata, s_axis_tlast);
        bytes_taken <= bytes_taken + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        seen_result = tcpop_pkg::result_t'(m_axis_tdata[tcpop_pkg::RESULT_W-1:0]);
        if (expected_results_q.size() == 0) begin
          flag_mismatch("result with none due", '0, 32'(m_axis_tdata));
        end else begin
          automatic tcpop_pkg::result_t want = expected_results_q.pop_front();
          if (seen_result.max_segment_size != want.max_segment_size) begin
            flag_mismatch("max_segment_size", 32'(want.max_segment_size),
                          32'(seen_result.max_segment_size));
          end
          if (seen_result.window_shift != want.window_shift) begin
            flag_mismatch("window_shift", 32'(want.window_shift),
                          32'(seen_result.window_shift));
          end
          if (seen_result.sack_allowed != want.sack_allowed) begin
            flag_mismatch("sack_allowed", 32'(want.sack_allowed),
                          32'(seen_result.sack_allowed));
          end
          if (seen_result.malformed != want.malformed) begin
            flag_mismatch("malformed", 32'(want.malformed), 32'(seen_result.malformed));
          end
          if (m_axis_tdata[tcpop_pkg::TDATA_W-1:tcpop_pkg::RESULT_W] != '0) begin
            flag_mismatch("padding", '0,
                          32'(m_axis_tdata[tcpop_pkg::TDATA_W-1:tcpop_pkg::RESULT_W]));
          end
        end
        results_seen++;
      end
    end
  end

  // moves the scratch area into the send queue, tlast on its final byte
  task automatic close_area();
    foreach (area_buf[i]) begin
      pending_bytes_q.push_back('{value: area_buf[i], last: (i == area_buf.size() - 1)});
    end
    area_buf.delete();
  endtask

  function automatic logic [7:0] known_length(input logic [7:0] usual);
    // length bytes of the known kinds are ignored, so now and then send junk
    return ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : usual;
  endfunction

  task automatic add_random_option();
    int unsigned pick;
    int unsigned opt_len;
    pick = $urandom_range(99);
    if (pick < 15) begin
      area_buf.push_back(tcpop_pkg::OPT_NOP);
    end else if (pick < 35) begin
      area_buf.push_back(tcpop_pkg::OPT_MSS);
      area_buf.push_back(known_length(8'd4));
      area_buf.push_back(8'($urandom_range(255)));
      area_buf.push_back(8'($urandom_range(255)));
    end else if (pick < 50) begin
      area_buf.push_back(tcpop_pkg::OPT_WSCALE);
      area_buf.push_back(known_length(8'd3));
      area_buf.push_back(8'($urandom_range(255)));
    end else if (pick < 62) begin
      area_buf.push_back(tcpop_pkg::OPT_SACK_OK);
      area_buf.push_back(known_length(8'd2));
    end else begin
      area_buf.push_back(8'($urandom_range(255, 5)));
      pick = $urandom_range(99);
      if (pick < 4) begin
        opt_len = $urandom_range(1);
      end else if (pick < 7) begin
        opt_len = $urandom_range(255, 13);
      end else begin
        opt_len = $urandom_range(12, 2);
      end
      area_buf.push_back(8'(opt_len));
      for (int unsigned k = 2; k < opt_len; k++) begin
        area_buf.push_back(8'($urandom_range(255)));
      end
    end
  endtask

  task automatic build_random_areas();
    int unsigned pick;
    int unsigned n_opts;
    int unsigned keep;
    while (pending_bytes_q.size() < bytes_total + RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        // noise
        n_opts = $urandom_range(8, 1);
        repeat (n_opts) area_buf.push_back(8'($urandom_range(255)));
      end else begin
        n_opts = $urandom_range(5, 1);
        repeat (n_opts) add_random_option();
        if ($urandom_range(99) < 30) begin
          area_buf.push_back(tcpop_pkg::OPT_END);
          repeat ($urandom_range(3)) area_buf.push_back(8'($urandom_range(255)));
        end
        // broken areas: cut off at an arbitrary byte
        if (pick < 24) begin
          keep = $urandom_range(area_buf.size(), 1);
          while (area_buf.size() > keep) void'(area_buf.pop_back());
        end
      end
      close_area();
    end
  endtask

  initial begin
    reset_parser_model();

    // every kind, segment size and shift at their top values
    area_buf = '{tcpop_pkg::OPT_MSS, 8'd4, 8'hFF, 8'hFF, tcpop_pkg::OPT_WSCALE, 8'd3,
                 8'hFF, tcpop_pkg::OPT_SACK_OK, 8'd2, tcpop_pkg::OPT_NOP,
                 tcpop_pkg::OPT_END};
    close_area();
    // unknown kind with a length below two, rest ignored
    area_buf = '{8'd9, 8'd1, 8'd5};
    close_area();
    // segment size cut off after its high byte
    area_buf = '{tcpop_pkg::OPT_MSS, 8'd4, 8'h00};
    close_area();
    // unknown option still skipping when the area ends
    area_buf = '{8'd8, 8'd5, 8'h0A, 8'h0B};
    close_area();
    // window scale without its length byte
    area_buf = '{tcpop_pkg::OPT_WSCALE};
    close_area();
    // unknown kind of length two, then end
    area_buf = '{8'd200, 8'd2, tcpop_pkg::OPT_END};
    close_area();
    // top kind with zero length
    area_buf = '{8'hFF, 8'h00};
    close_area();

    bytes_total = pending_bytes_q.size();
    build_random_areas();
    bytes_total = pending_bytes_q.size();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while ((bytes_taken < bytes_total || expected_results_q.size() != 0) &&
           cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
    end
    if (expected_results_q.size() != 0) begin
      $display("%0d results never arrived", expected_results_q.size());
    end
    if (cycle_count < CYCLE_LIMIT && mismatches == 0 && expected_results_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/tcpop_pkg.sv
hw/rtl/tcpop_parse.sv
hw/rtl/tcp_option_parser.sv
verif/tcp_option_parser_test.sv
